>>> src/dcwf_pkg.sv
// ----------------------------------------------------------------------------
// dcwf_pkg
// Shared constants, types and helpers for the DNA complex wavelet FIR.
// ----------------------------------------------------------------------------
`default_nettype none

package dcwf_pkg;

  // Sizing
  localparam int MAX_TAPS = 256;
  localparam int COEF_W   = 16;
  localparam int IDX_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAP_W    = $clog2(MAX_TAPS + 1);
  localparam int CFG_W    = 9;
  localparam int BASE_W   = 8;
  localparam int CIDX_W   = 8;
  localparam int FIELD_W  = 16;
  localparam int OUT_W    = 26;
  localparam int CODE_W   = 3;
  // One term is at most 2^COEF_W in magnitude
  localparam int TERM_W   = COEF_W + 2;
  localparam int ACC_W    = COEF_W + $clog2(MAX_TAPS) + 2;
  localparam int SUM_W    = (ACC_W > OUT_W) ? ACC_W : OUT_W;

  // Saturation bounds of the result, at accumulator width
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  // Command codes
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_PAD   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // Base characters
  localparam logic [BASE_W-1:0] CHAR_UA = 8'h41;
  localparam logic [BASE_W-1:0] CHAR_LA = 8'h61;
  localparam logic [BASE_W-1:0] CHAR_UT = 8'h54;
  localparam logic [BASE_W-1:0] CHAR_LT = 8'h74;
  localparam logic [BASE_W-1:0] CHAR_UG = 8'h47;
  localparam logic [BASE_W-1:0] CHAR_LG = 8'h67;
  localparam logic [BASE_W-1:0] CHAR_UC = 8'h43;
  localparam logic [BASE_W-1:0] CHAR_LC = 8'h63;

  // Sample codes: bit 2 nonzero, bit 1 real negative, bit 0 imag negative
  localparam logic [CODE_W-1:0] CODE_ZERO = 3'b000;
  localparam logic [CODE_W-1:0] CODE_A    = 3'b100;
  localparam logic [CODE_W-1:0] CODE_T    = 3'b101;
  localparam logic [CODE_W-1:0] CODE_G    = 3'b110;
  localparam logic [CODE_W-1:0] CODE_C    = 3'b111;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                     push;
    logic                     clear;
    logic                     load;
    logic [IDX_W-1:0]         load_idx;
    logic signed [COEF_W-1:0] coef_re;
    logic signed [COEF_W-1:0] coef_im;
    logic                     acc_clr;
    logic                     shift;
    logic [TAP_W-1:0]         taps;
  } cell_ctrl_t;

  // Map a raw base character to its sample code
  function automatic logic [CODE_W-1:0] base_code(input logic [BASE_W-1:0] b);
    logic [CODE_W-1:0] c;
    c = CODE_ZERO;
    if (b == CHAR_UA || b == CHAR_LA) c = CODE_A;
    if (b == CHAR_UT || b == CHAR_LT) c = CODE_T;
    if (b == CHAR_UG || b == CHAR_LG) c = CODE_G;
    if (b == CHAR_UC || b == CHAR_LC) c = CODE_C;
    return c;
  endfunction

  // Keep the low COEF_W bits of the sign-extended field
  function automatic logic signed [COEF_W-1:0] coef_trim(
    input logic signed [FIELD_W-1:0] f
  );
    logic signed [31:0] ext;
    ext = 32'(f);
    return ext[COEF_W-1:0];
  endfunction

  // Clamp the accumulator to the signed result range
  function automatic logic signed [OUT_W-1:0] sat_out(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> src/dcwf_cell.sv
// ----------------------------------------------------------------------------
// dcwf_cell
// One tap of the filter chain: a history sample, a complex coefficient and
// a pair of partial sums that move one cell toward tap 0 per sweep step.
// ----------------------------------------------------------------------------
`default_nettype none

module dcwf_cell (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire dcwf_pkg::cell_ctrl_t                  ctrl_i,
  input  wire logic [dcwf_pkg::IDX_W-1:0]            cell_idx_i,
  input  wire logic [dcwf_pkg::CODE_W-1:0]           hist_i,
  output logic      [dcwf_pkg::CODE_W-1:0]           hist_o,
  input  wire logic signed [dcwf_pkg::SUM_W-1:0]     acc_re_i,
  input  wire logic signed [dcwf_pkg::SUM_W-1:0]     acc_im_i,
  output logic      signed [dcwf_pkg::SUM_W-1:0]     acc_re_o,
  output logic      signed [dcwf_pkg::SUM_W-1:0]     acc_im_o
);

  logic [dcwf_pkg::CODE_W-1:0]          hist_q;
  logic signed [dcwf_pkg::COEF_W-1:0]   coef_re_q, coef_im_q;
  logic signed [dcwf_pkg::SUM_W-1:0]    acc_re_q, acc_im_q;
  logic signed [dcwf_pkg::TERM_W-1:0]   wr_x, wi_x, xr_wr, xr_wi, xi_wr, xi_wi;
  logic signed [dcwf_pkg::TERM_W-1:0]   term_re, term_im;
  logic                                 tap_on;

  // History sample and coefficient
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q    <= dcwf_pkg::CODE_ZERO;
      coef_re_q <= '0;
      coef_im_q <= '0;
    end else begin
      if (ctrl_i.clear) begin
        hist_q <= dcwf_pkg::CODE_ZERO;
      end else if (ctrl_i.push) begin
        hist_q <= hist_i;
      end
      if (ctrl_i.load && (ctrl_i.load_idx == cell_idx_i)) begin
        coef_re_q <= ctrl_i.coef_re;
        coef_im_q <= ctrl_i.coef_im;
      end
    end
  end

  // Complex product of a sample with +/-1 parts and the coefficient
  always_comb begin
    wr_x    = dcwf_pkg::TERM_W'(coef_re_q);
    wi_x    = dcwf_pkg::TERM_W'(coef_im_q);
    xr_wr   = hist_q[1] ? -wr_x : wr_x;
    xr_wi   = hist_q[1] ? -wi_x : wi_x;
    xi_wr   = hist_q[0] ? -wr_x : wr_x;
    xi_wi   = hist_q[0] ? -wi_x : wi_x;
    tap_on  = hist_q[2] && (dcwf_pkg::TAP_W'(cell_idx_i) < ctrl_i.taps);
    term_re = tap_on ? (xr_wr - xi_wi) : '0;
    term_im = tap_on ? (xr_wi + xi_wr) : '0;
  end

  // Partial sums: cleared at the start of a sweep, then passed down the chain
  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_clr) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (ctrl_i.shift) begin
      acc_re_q <= acc_re_i + dcwf_pkg::SUM_W'(term_re);
      acc_im_q <= acc_im_i + dcwf_pkg::SUM_W'(term_im);
    end
  end

  assign hist_o   = hist_q;
  assign acc_re_o = acc_re_q;
  assign acc_im_o = acc_im_q;

endmodule

`default_nettype wire

>>> src/dna_complex_wavelet_fir.sv
// ----------------------------------------------------------------------------
// dna_complex_wavelet_fir
// Centered complex FIR over a DNA base stream, built as a chain of tap cells.
// A push that emits clears the partial sums, sweeps them down the cell chain
//   to tap 0, then loads the saturated result into the output register.
// in_ready is low during the sweep and while the result waits; loads, clears
//   and pushes inside the centering offset are taken whenever idle.
// Reset: history and coefficients zero, position zero, tap_count 1.
// ----------------------------------------------------------------------------
`default_nettype none

module dna_complex_wavelet_fir (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // input channel
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [1:0]                            command_i,
  input  wire logic [dcwf_pkg::BASE_W-1:0]           base_byte_i,
  input  wire logic [dcwf_pkg::CIDX_W-1:0]           coef_index_i,
  input  wire logic signed [dcwf_pkg::FIELD_W-1:0]   coef_real_i,
  input  wire logic signed [dcwf_pkg::FIELD_W-1:0]   coef_imag_i,
  // configuration
  input  wire logic                                  cfg_we_i,
  input  wire logic [dcwf_pkg::CFG_W-1:0]            cfg_wdata_i,
  // output channel
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [dcwf_pkg::OUT_W-1:0]          out_real_o,
  output logic signed [dcwf_pkg::OUT_W-1:0]          out_imag_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_e;

  state_e                                state_q;
  logic [dcwf_pkg::CFG_W-1:0]            taps_cfg_q;
  logic [dcwf_pkg::TAP_W-1:0]            pushed_q, pushed_d;
  logic [dcwf_pkg::TAP_W-1:0]            count_q;
  logic                                  out_valid_q;
  logic signed [dcwf_pkg::OUT_W-1:0]     out_real_q, out_imag_q;

  logic [dcwf_pkg::TAP_W-1:0]            taps_eff, half;
  logic                                  accept, is_push, is_clear, is_load, emit, finish;
  dcwf_pkg::cmd_e                        cmd;
  dcwf_pkg::cell_ctrl_t                  ctrl;
  logic [dcwf_pkg::CODE_W-1:0]           new_code;

  logic [dcwf_pkg::CODE_W-1:0]           hist_w   [dcwf_pkg::MAX_TAPS+1];
  logic signed [dcwf_pkg::SUM_W-1:0]     acc_re_w [dcwf_pkg::MAX_TAPS+1];
  logic signed [dcwf_pkg::SUM_W-1:0]     acc_im_w [dcwf_pkg::MAX_TAPS+1];

  // Tap count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_cfg_q <= dcwf_pkg::CFG_W'(1);
    end else if (cfg_we_i) begin
      taps_cfg_q <= cfg_wdata_i;
    end
  end

  // Effective tap count and centering offset
  always_comb begin
    if (taps_cfg_q == '0) begin
      taps_eff = dcwf_pkg::TAP_W'(1);
    end else if (32'(taps_cfg_q) > 32'(dcwf_pkg::MAX_TAPS)) begin
      taps_eff = dcwf_pkg::TAP_W'(dcwf_pkg::MAX_TAPS);
    end else begin
      taps_eff = dcwf_pkg::TAP_W'(taps_cfg_q);
    end
    half = taps_eff >> 1;
  end

  // Transaction decode
  always_comb begin
    cmd        = dcwf_pkg::cmd_e'(command_i);
    in_ready_o = (state_q == ST_IDLE);
    accept     = in_valid_i && in_ready_o;
    is_push    = accept && (cmd == dcwf_pkg::CMD_PUSH || cmd == dcwf_pkg::CMD_PAD);
    is_clear   = accept && (cmd == dcwf_pkg::CMD_CLEAR);
    is_load    = accept && (cmd == dcwf_pkg::CMD_LOAD)
                 && (32'(coef_index_i) < 32'(dcwf_pkg::MAX_TAPS));
    emit       = is_push && (pushed_q >= half);
    finish     = (state_q == ST_SWEEP) && (count_q == '0)
                 && (!out_valid_q || out_ready_i);
    new_code   = (cmd == dcwf_pkg::CMD_PUSH) ? dcwf_pkg::base_code(base_byte_i)
                                             : dcwf_pkg::CODE_ZERO;
  end

  // Position counter, saturating at the chain length
  always_comb begin
    pushed_d = pushed_q;
    if (is_clear) begin
      pushed_d = '0;
    end else if (is_push && (32'(pushed_q) < 32'(dcwf_pkg::MAX_TAPS))) begin
      pushed_d = pushed_q + dcwf_pkg::TAP_W'(1);
    end
  end

  // Broadcast control to the cells
  always_comb begin
    ctrl.push     = is_push;
    ctrl.clear    = is_clear;
    ctrl.load     = is_load;
    ctrl.load_idx = dcwf_pkg::IDX_W'(coef_index_i);
    ctrl.coef_re  = dcwf_pkg::coef_trim(coef_real_i);
    ctrl.coef_im  = dcwf_pkg::coef_trim(coef_imag_i);
    ctrl.acc_clr  = emit;
    ctrl.shift    = (state_q == ST_SWEEP) && (count_q != '0);
    ctrl.taps     = taps_eff;
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pushed_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_real_q  <= '0;
      out_imag_q  <= '0;
    end else begin
      pushed_q <= pushed_d;
      unique case (state_q)
        ST_IDLE: begin
          if (emit) begin
            state_q <= ST_SWEEP;
            count_q <= taps_eff;
          end
        end
        ST_SWEEP: begin
          if (count_q != '0) begin
            count_q <= count_q - dcwf_pkg::TAP_W'(1);
          end else if (finish) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (finish) begin
        out_valid_q <= 1'b1;
        out_real_q  <= dcwf_pkg::sat_out(acc_re_w[0]);
        out_imag_q  <= dcwf_pkg::sat_out(acc_im_w[0]);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Cell chain: samples move up, partial sums move down toward tap 0
  assign hist_w[0]                     = new_code;
  assign acc_re_w[dcwf_pkg::MAX_TAPS]  = '0;
  assign acc_im_w[dcwf_pkg::MAX_TAPS]  = '0;

  for (genvar g = 0; g < dcwf_pkg::MAX_TAPS; g++) begin : g_cell
    dcwf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .cell_idx_i (dcwf_pkg::IDX_W'(g)),
      .hist_i     (hist_w[g]),
      .hist_o     (hist_w[g+1]),
      .acc_re_i   (acc_re_w[g+1]),
      .acc_im_i   (acc_im_w[g+1]),
      .acc_re_o   (acc_re_w[g]),
      .acc_im_o   (acc_im_w[g])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_real_o  = out_real_q;
  assign out_imag_o  = out_imag_q;

endmodule

`default_nettype wire

>>> dv/dna_complex_wavelet_fir_test.sv
// ----------------------------------------------------------------------------
// dna_complex_wavelet_fir_test
// Self-checking testbench for the centered complex FIR over DNA bases. A
// local predictor keeps its own history, coefficients and position, builds
// the expected samples for every accepted transaction, and the output
// monitor compares each result field by field against the oldest one.
// ----------------------------------------------------------------------------

module dna_complex_wavelet_fir_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dcwf_pkg::*;

  localparam longint OUT_HI = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint OUT_LO = -(longint'(1) <<< (OUT_W - 1));

  typedef struct packed {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
  } conv_sample_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_BURSTY, RX_DUTY} rx_mode_e;

  // DUT ports
  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [1:0]                 command_i;
  logic [BASE_W-1:0]          base_byte_i;
  logic [CIDX_W-1:0]          coef_index_i;
  logic signed [FIELD_W-1:0]  coef_real_i;
  logic signed [FIELD_W-1:0]  coef_imag_i;
  logic                       cfg_we_i;
  logic [CFG_W-1:0]           cfg_wdata_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [OUT_W-1:0]    out_real_o;
  logic signed [OUT_W-1:0]    out_imag_o;

  // Predictor state
  logic [CODE_W-1:0]          base_hist [MAX_TAPS];
  logic signed [FIELD_W-1:0]  tap_re [MAX_TAPS];
  logic signed [FIELD_W-1:0]  tap_im [MAX_TAPS];
  int unsigned                push_pos;
  logic [CFG_W-1:0]           tap_setting;
  conv_sample_t               pending_samples [$];

  // Traffic control
  int unsigned                error_count = 0;
  int unsigned                items_sent = 0;
  int unsigned                burst_left = 0;
  bit                         sender_idles = 1'b0;
  rx_mode_e                   rx_mode = RX_ALWAYS;
  int unsigned                stall_left = 0;
  int unsigned                duty_phase = 0;

  dna_complex_wavelet_fir i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .base_byte_i  (base_byte_i),
    .coef_index_i (coef_index_i),
    .coef_real_i  (coef_real_i),
    .coef_imag_i  (coef_imag_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_real_o   (out_real_o),
    .out_imag_o   (out_imag_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #30_000_000;
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Zero and out-of-range settings fold into 1..MAX_TAPS
  function automatic int unsigned taps_in_use();
    if (tap_setting == 0) return 1;
    if (tap_setting > MAX_TAPS) return MAX_TAPS;
    return tap_setting;
  endfunction

  function automatic logic [CODE_W-1:0] code_of_base(logic [BASE_W-1:0] b);
    case (b)
      CHAR_UA, CHAR_LA: return CODE_A;
      CHAR_UT, CHAR_LT: return CODE_T;
      CHAR_UG, CHAR_LG: return CODE_G;
      CHAR_UC, CHAR_LC: return CODE_C;
      default:          return CODE_ZERO;
    endcase
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_sum(longint v);
    longint r;
    r = v;
    if (r > OUT_HI) r = OUT_HI;
    if (r < OUT_LO) r = OUT_LO;
    return r[OUT_W-1:0];
  endfunction

  // Apply one accepted transaction; queue a sample when a push emits
  function automatic void predict_filter(cmd_e cmd, logic [BASE_W-1:0] b,
                                         logic [CIDX_W-1:0] idx,
                                         logic signed [FIELD_W-1:0] re,
                                         logic signed [FIELD_W-1:0] im);
    conv_sample_t s;
    longint acc_re, acc_im, wr, wi, xr, xi;
    int unsigned pos, n;
    case (cmd)
      CMD_LOAD: begin
        if (idx < MAX_TAPS) begin
          tap_re[idx] = re;
          tap_im[idx] = im;
        end
      end
      CMD_CLEAR: begin
        foreach (base_hist[k]) base_hist[k] = CODE_ZERO;
        push_pos = 0;
      end
      default: begin
        for (int k = MAX_TAPS - 1; k > 0; k--) base_hist[k] = base_hist[k-1];
        base_hist[0] = (cmd == CMD_PUSH) ? code_of_base(b) : CODE_ZERO;
        pos = push_pos;
        if (push_pos < MAX_TAPS) push_pos++;
        n = taps_in_use();
        // nothing comes out until the centering offset is passed
        if (pos >= n / 2) begin
          acc_re = 0;
          acc_im = 0;
          for (int k = 0; k < n; k++) begin
            if (base_hist[k][2]) begin
              xr = base_hist[k][1] ? -1 : 1;
              xi = base_hist[k][0] ? -1 : 1;
              wr = tap_re[k];
              wi = tap_im[k];
              acc_re += xr * wr - xi * wi;
              acc_im += xr * wi + xi * wr;
            end
          end
          s.re = clamp_sum(acc_re);
          s.im = clamp_sum(acc_im);
          pending_samples.push_back(s);
        end
      end
    endcase
  endfunction

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= 50) $display("[%0t] ERROR: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: check results, then predict from accepted inputs
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    conv_sample_t exp_s;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_samples.size() == 0) begin
          report_error($sformatf("unexpected result re=%0d im=%0d",
                                 out_real_o, out_imag_o));
        end else begin
          exp_s = pending_samples.pop_front();
          if (out_real_o !== exp_s.re)
            report_error($sformatf("out_real got %0d expected %0d",
                                   out_real_o, exp_s.re));
          if (out_imag_o !== exp_s.im)
            report_error($sformatf("out_imag got %0d expected %0d",
                                   out_imag_o, exp_s.im));
        end
      end
      if (in_valid_i && in_ready_o)
        predict_filter(cmd_e'(command_i), base_byte_i, coef_index_i,
                       coef_real_i, coef_imag_i);
    end
  end

  // Output backpressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready_i = 1'b1;
        RX_RANDOM: out_ready_i = ($urandom_range(0, 3) != 0);
        RX_BURSTY: begin
          out_ready_i = 1'b1;
          if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 30);
        end
        default: begin
          duty_phase++;
          out_ready_i = (duty_phase % 5) < 3;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // One input transaction, with optional gaps between bursts
  task automatic send_item(cmd_e cmd, logic [BASE_W-1:0] b,
                           logic [CIDX_W-1:0] idx,
                           logic signed [FIELD_W-1:0] re,
                           logic signed [FIELD_W-1:0] im);
    @(negedge clk_i);
    if (sender_idles && burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    command_i    = cmd;
    base_byte_i  = b;
    coef_index_i = idx;
    coef_real_i  = re;
    coef_imag_i  = im;
    in_valid_i   = 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    items_sent++;
  endtask

  task automatic push_base(logic [BASE_W-1:0] b);
    send_item(CMD_PUSH, b, CIDX_W'($urandom), FIELD_W'($urandom),
              FIELD_W'($urandom));
  endtask

  task automatic push_pad();
    send_item(CMD_PAD, BASE_W'($urandom), CIDX_W'($urandom), FIELD_W'($urandom),
              FIELD_W'($urandom));
  endtask

  task automatic clear_history();
    send_item(CMD_CLEAR, BASE_W'($urandom), CIDX_W'($urandom), FIELD_W'($urandom),
              FIELD_W'($urandom));
  endtask

  task automatic load_coef(logic [CIDX_W-1:0] idx, logic signed [FIELD_W-1:0] re,
                           logic signed [FIELD_W-1:0] im);
    send_item(CMD_LOAD, BASE_W'($urandom), idx, re, im);
  endtask

  // Hold the sender until every result is out, then let the pipe settle
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_samples.size() != 0) @(negedge clk_i);
    repeat (taps_in_use() + 4) @(negedge clk_i);
  endtask

  task automatic set_taps(int unsigned v);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = CFG_W'(v);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    tap_setting = CFG_W'(v);
  endtask

  function automatic logic signed [FIELD_W-1:0] random_coef();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // Mostly valid bases in both cases, sometimes any byte
  function automatic logic [BASE_W-1:0] random_base();
    if ($urandom_range(0, 6) == 0) return BASE_W'($urandom);
    case ($urandom_range(0, 7))
      0:       return CHAR_UA;
      1:       return CHAR_LA;
      2:       return CHAR_UT;
      3:       return CHAR_LT;
      4:       return CHAR_UG;
      5:       return CHAR_LG;
      6:       return CHAR_UC;
      default: return CHAR_LC;
    endcase
  endfunction

  // Load a few taps, clear, stream bases, flush the tail with padding
  task automatic run_frame();
    int unsigned n;
    n = taps_in_use();
    repeat ($urandom_range(0, (n < 6) ? n : 6))
      load_coef(CIDX_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, n - 1)),
                random_coef(), random_coef());
    if ($urandom_range(0, 5) != 0) clear_history();
    repeat ($urandom_range(1, (n < 16) ? n + 8 : 24)) push_base(random_base());
    if ($urandom_range(0, 4) != 0) repeat (n / 2) push_pad();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Default single tap with zero coefficients: every push gives zero
  task automatic test_after_reset();
    push_base(CHAR_UA);
    push_base(8'h00);
    push_pad();
  endtask

  // Every base character, other bytes, padding, and the centering offset
  task automatic test_base_mapping();
    set_taps(3);
    load_coef(8'd0, 16'sd16384, 16'sd0);
    load_coef(8'd1, 16'sd0, 16'sd16384);
    load_coef(8'd2, -16'sd8192, 16'sd4096);
    load_coef(8'd3, 16'sh7fff, 16'sh7fff);
    load_coef(8'hff, 16'sh7fff, 16'sh8000);
    clear_history();
    push_base(CHAR_UA);
    push_base(CHAR_LA);
    push_base(CHAR_UT);
    push_base(CHAR_LT);
    push_base(CHAR_UG);
    push_base(CHAR_LG);
    push_base(CHAR_UC);
    push_base(CHAR_LC);
    push_base("N");
    push_base(8'h00);
    push_base(8'hff);
    push_pad();
    push_pad();
  endtask

  // All taps at the most negative weight: drives large real results of both
  // signs and runs the position counter into saturation
  task automatic test_full_scale();
    set_taps(256);
    for (int k = 0; k < MAX_TAPS; k++) load_coef(CIDX_W'(k), 16'sh8000, 16'sh8000);
    clear_history();
    repeat (MAX_TAPS) push_base(($urandom_range(0, 1) == 0) ? CHAR_UG : CHAR_LG);
    repeat (MAX_TAPS) push_base(($urandom_range(0, 1) == 0) ? CHAR_UT : CHAR_LT);
  endtask

  // Random frames and noise over a range of tap settings and idle patterns
  task automatic test_random_traffic();
    int unsigned phase_taps [12] = '{3, 1, 0, 5, 8, 2, 17, 33, 4, 64, 255, 511};
    int unsigned phase_items [12] = '{60, 50, 30, 60, 60, 50, 60, 50, 50, 40, 20, 20};
    int unsigned stop_at;
    foreach (phase_taps[i]) begin
      set_taps(phase_taps[i]);
      rx_mode      = rx_mode_e'(i % 4);
      sender_idles = (i % 3 != 1);
      stop_at      = items_sent + phase_items[i];
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 9) < 8)
          run_frame();
        else
          send_item(cmd_e'($urandom_range(0, 3)), BASE_W'($urandom),
                    CIDX_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
        // occasional full stop until the pipeline is empty
        if ($urandom_range(0, 7) == 0) drain_results();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    command_i    = CMD_LOAD;
    base_byte_i  = '0;
    coef_index_i = '0;
    coef_real_i  = '0;
    coef_imag_i  = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    out_ready_i  = 1'b1;
    foreach (base_hist[k]) begin
      base_hist[k] = CODE_ZERO;
      tap_re[k]    = '0;
      tap_im[k]    = '0;
    end
    push_pos    = 0;
    tap_setting = 1;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_after_reset();
    sender_idles = 1'b1;
    rx_mode      = RX_RANDOM;
    test_base_mapping();
    rx_mode = RX_BURSTY;
    test_full_scale();
    test_random_traffic();

    drain_results();
    if (pending_samples.size() != 0)
      report_error($sformatf("%0d expected results never arrived",
                             pending_samples.size()));
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
